// ===== rtl/rvsm_pkg.sv =====
// Shared constants, codes and interface types of the ramped volume sample mixer.
package rvsm_pkg;

    localparam int STORE_DEPTH    = 4096;
    localparam int INTERP_SHIFT   = 16;
    localparam int VOLUME_DIVISOR = 128;

    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int FUNC_W     = 2;
    localparam int SADDR_W    = 12;
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 44;
    localparam int FRAC_W     = 32;
    localparam int POS_INT_W  = POS_W - FRAC_W;
    localparam int ACC_W      = 32;
    localparam int VOL_W      = 32;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 44;
    localparam int BLEND_W    = SAMPLE_W + INTERP_SHIFT + 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MIX   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIX_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_INC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LVOL_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RVOL_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LVOL_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RVOL_STEP  = 3'd5;

    localparam logic [1:0] KIND_STEREO   = 2'd1;
    localparam logic [1:0] KIND_SURROUND = 2'd2;

    // modulo-depth reduction: values are biased by a multiple of the depth to stay positive
    localparam int WRAP_NEG_SPAN = 2 ** (POS_INT_W - 1);
    localparam int WRAP_OFS      = STORE_DEPTH * ((WRAP_NEG_SPAN + STORE_DEPTH - 1) / STORE_DEPTH);
    localparam int WRAP_MAX      = STORE_DEPTH + (2 ** POS_INT_W) - 1 + WRAP_OFS;
    localparam int WRAP_W        = $clog2(WRAP_MAX + 1);
    localparam int WRAP_QW       = $clog2(WRAP_MAX / STORE_DEPTH + 1);
    localparam int WRAP_KW       = (WRAP_QW > 1) ? $clog2(WRAP_QW) : 1;

    // truncating divide by reciprocal, one correction step
    localparam int DIV_LOG     = $clog2(VOLUME_DIVISOR);
    localparam int RECIP_SHIFT = 31 + DIV_LOG;
    localparam int DIV_W       = $clog2(VOLUME_DIVISOR + 1);
    localparam logic [63:0]      RECIP_FULL = (64'd1 << RECIP_SHIFT) / VOLUME_DIVISOR;
    localparam logic [VOL_W-1:0] RECIP_M    = VOL_W'(RECIP_FULL);
    localparam logic [DIV_W-1:0] DIV_K      = DIV_W'(VOLUME_DIVISOR);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_WRAP,
        ST_BEGIN_WRAP,
        ST_MIX_RD0,
        ST_MIX_RD1,
        ST_MIX_BLEND,
        ST_MIX_INTERP,
        ST_MIX_SCALE_L,
        ST_MIX_SCALE_R,
        ST_MIX_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WRAP_W-1:0] value;
    } wrap_req_t;

    typedef struct packed {
        logic              busy;
        logic [ADDR_W-1:0] result;
    } wrap_rsp_t;

    typedef struct packed {
        logic                start;
        logic [VOL_W-1:0]    volume;
        logic [SAMPLE_W-1:0] sample;
    } scale_req_t;

    typedef struct packed {
        logic             done;
        logic [VOL_W-1:0] result;
    } scale_rsp_t;

endpackage

// ===== rtl/rvsm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rvsm_wrap.sv =====
// Iterative modulo-depth reducer: one conditional subtract of a shifted depth per cycle.
module rvsm_wrap (
    input  logic               clk,
    input  logic               rst_n,
    input  rvsm_pkg::wrap_req_t req,
    output rvsm_pkg::wrap_rsp_t rsp
);

    import rvsm_pkg::*;

    logic [WRAP_W-1:0]  x_reg, x_next;
    logic [WRAP_KW-1:0] k_reg, k_next;
    logic               busy_reg, busy_next;
    logic [WRAP_W-1:0]  dsh;

    always_comb
    begin
        dsh       = WRAP_W'(STORE_DEPTH) << k_reg;
        x_next    = x_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            x_next    = req.value;
            k_next    = WRAP_KW'(WRAP_QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg >= dsh)
            begin
                x_next = x_reg - dsh;
            end
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.result = x_reg[ADDR_W-1:0];

endmodule

// ===== rtl/rvsm_scale.sv =====
// Five-stage volume scaler: wrapped 32-bit product, then truncating divide by a constant.
module rvsm_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  rvsm_pkg::scale_req_t req,
    output rvsm_pkg::scale_rsp_t rsp
);

    import rvsm_pkg::*;

    logic signed [VOL_W-1:0]          vol_s;
    logic signed [SAMPLE_W-1:0]       smp_s;
    logic signed [VOL_W+SAMPLE_W-1:0] prod_full;
    logic [2*VOL_W-1:0]               recip_full;
    logic [VOL_W+DIV_W-1:0]           qd_full;
    logic [VOL_W-1:0]                 rem;
    logic [VOL_W-1:0]                 q;

    logic [4:0]       vld_reg;
    logic [VOL_W-1:0] prod_reg;
    logic             neg2_reg, neg3_reg, neg4_reg;
    logic [VOL_W-1:0] mag2_reg, mag3_reg, mag4_reg;
    logic [VOL_W-1:0] qe3_reg, qe4_reg;
    logic [VOL_W-1:0] qd4_reg;
    logic [VOL_W-1:0] res_reg;

    assign vol_s      = req.volume;
    assign smp_s      = req.sample;
    assign prod_full  = vol_s * smp_s;
    assign recip_full = mag2_reg * RECIP_M;
    assign qd_full    = qe3_reg * DIV_K;
    assign rem        = mag4_reg - qd4_reg;
    assign q          = (rem >= VOL_W'(VOLUME_DIVISOR)) ? qe4_reg + 1'b1 : qe4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], req.start};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[VOL_W-1:0];
        neg2_reg <= prod_reg[VOL_W-1];
        mag2_reg <= prod_reg[VOL_W-1] ? (~prod_reg + 1'b1) : prod_reg;
        neg3_reg <= neg2_reg;
        mag3_reg <= mag2_reg;
        qe3_reg  <= VOL_W'(recip_full >> RECIP_SHIFT);
        neg4_reg <= neg3_reg;
        mag4_reg <= mag3_reg;
        qe4_reg  <= qe3_reg;
        qd4_reg  <= qd_full[VOL_W-1:0];
        res_reg  <= neg4_reg ? (~q + 1'b1) : q;
    end

    assign rsp.done   = vld_reg[4];
    assign rsp.result = res_reg;

endmodule

// ===== rtl/ramped_volume_sample_mixer.sv =====
// Top level of the ramped volume sample mixer voice.
//
// One transaction is taken at a time. A load waits on the iterative modulo-depth reducer that
// folds the address; a begin waits on the same. A mix runs two reads from the sample store,
// a blend and an interpolate step when interpolation is on, and the five-stage volume scaler
// that handles left then right. The output register lets the next transaction start while a
// result waits to be taken.
module ramped_volume_sample_mixer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rvsm_pkg::FUNC_W-1:0]          func,
    input  logic [rvsm_pkg::SADDR_W-1:0]         sample_address,
    input  logic signed [rvsm_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [rvsm_pkg::POS_W-1:0]           start_position,
    input  logic                                 reload_volume,
    input  logic signed [rvsm_pkg::ACC_W-1:0]    accum_left_in,
    input  logic signed [rvsm_pkg::ACC_W-1:0]    accum_right_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rvsm_pkg::ACC_W-1:0]    accum_left_out,
    output logic signed [rvsm_pkg::ACC_W-1:0]    accum_right_out,
    output logic                                 mixed,
    input  logic                                 cfg_we,
    input  logic [rvsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rvsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import rvsm_pkg::*;

    state_t state_reg, state_next;

    logic [MODE_W-1:0]       mode_reg;
    logic [POS_W-1:0]        inc_reg;
    logic [VOL_W-1:0]        lvol_start_reg, rvol_start_reg;
    logic [VOL_W-1:0]        lstep_reg, rstep_reg;

    logic [ADDR_W-1:0]       pos_int_reg;
    logic [FRAC_W-1:0]       pos_frac_reg;
    logic [FRAC_W-1:0]       new_frac_reg;
    logic [VOL_W-1:0]        lvol_reg, rvol_reg;

    logic [SAMPLE_W-1:0]     smp_in_reg;
    logic [ACC_W-1:0]        accl_in_reg, accr_in_reg;
    logic signed [SAMPLE_W-1:0] s0_reg;
    logic [SAMPLE_W-1:0]     smp_reg;
    logic signed [BLEND_W-1:0] blend_reg;
    logic [VOL_W-1:0]        sl_reg, sr_reg;
    logic                    got_l_reg, got_r_reg;

    logic [ACC_W-1:0]        res_l_reg, res_r_reg;
    logic                    res_mix_reg;
    logic                    out_valid_reg;
    logic [ACC_W-1:0]        accl_out_reg, accr_out_reg;
    logic                    mixed_out_reg;

    logic                    accept;
    logic                    out_free;
    logic                    interp;
    logic [1:0]              kind;

    wrap_req_t               wreq;
    wrap_rsp_t               wrsp;
    scale_req_t              sreq;
    scale_rsp_t              srsp;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_s;

    logic [FRAC_W:0]         frac_sum;
    logic signed [POS_INT_W-1:0] inc_int;
    logic [WRAP_W:0]         adv_sum;
    logic [ADDR_W-1:0]       nbr;
    logic [INTERP_SHIFT-1:0] frac_f;
    logic signed [INTERP_SHIFT:0] frac_s;
    logic signed [SAMPLE_W:0] diff;
    logic signed [BLEND_W-1:0] blend_full;
    logic signed [BLEND_W-1:0] bsum;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign interp   = mode_reg[0];
    assign kind     = mode_reg[2:1];

    assign rd_s       = ram_rdata;
    assign frac_sum   = {1'b0, pos_frac_reg} + {1'b0, inc_reg[FRAC_W-1:0]};
    assign inc_int    = inc_reg[POS_W-1:FRAC_W];
    assign adv_sum    = (WRAP_W+1)'(pos_int_reg) + (WRAP_W+1)'(inc_int)
                      + (WRAP_W+1)'(frac_sum[FRAC_W]) + (WRAP_W+1)'(WRAP_OFS);
    assign nbr        = (pos_int_reg == ADDR_W'(STORE_DEPTH - 1)) ? '0 : pos_int_reg + 1'b1;
    assign frac_f     = pos_frac_reg[FRAC_W-1 -: INTERP_SHIFT];
    assign frac_s     = {1'b0, frac_f};
    assign diff       = (SAMPLE_W+1)'(rd_s) - (SAMPLE_W+1)'(s0_reg);
    assign blend_full = diff * frac_s;
    assign bsum       = BLEND_W'(s0_reg) + (blend_reg >>> INTERP_SHIFT);

    rvsm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wrsp.result),
        .wdata (smp_in_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rvsm_wrap u_wrap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wreq),
        .rsp   (wrsp)
    );

    rvsm_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rsp   (srsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        wreq.start   = 1'b0;
        wreq.value   = adv_sum[WRAP_W-1:0];
        sreq.start   = 1'b0;
        sreq.volume  = lvol_reg;
        sreq.sample  = smp_reg;
        ram_we       = 1'b0;
        ram_raddr    = pos_int_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_LOAD:
                        begin
                            wreq.start = 1'b1;
                            wreq.value = WRAP_W'(sample_address);
                            state_next = ST_LOAD_WRAP;
                        end
                        FUNC_BEGIN:
                        begin
                            wreq.start = 1'b1;
                            wreq.value = WRAP_W'(start_position[POS_W-1:FRAC_W]);
                            state_next = ST_BEGIN_WRAP;
                        end
                        FUNC_MIX:
                        begin
                            state_next = ST_MIX_RD0;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_LOAD_WRAP:
            begin
                if (!wrsp.busy)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_BEGIN_WRAP:
            begin
                if (!wrsp.busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_MIX_RD0:
            begin
                wreq.start = 1'b1;
                state_next = ST_MIX_RD1;
            end
            ST_MIX_RD1:
            begin
                ram_raddr  = nbr;
                state_next = interp ? ST_MIX_BLEND : ST_MIX_SCALE_L;
            end
            ST_MIX_BLEND:
            begin
                state_next = ST_MIX_INTERP;
            end
            ST_MIX_INTERP:
            begin
                state_next = ST_MIX_SCALE_L;
            end
            ST_MIX_SCALE_L:
            begin
                sreq.start = 1'b1;
                state_next = ST_MIX_SCALE_R;
            end
            ST_MIX_SCALE_R:
            begin
                sreq.start  = 1'b1;
                sreq.volume = rvol_reg;
                state_next  = ST_MIX_WAIT;
            end
            ST_MIX_WAIT:
            begin
                if (got_r_reg && !wrsp.busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration, voice state and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            inc_reg        <= POS_W'(64'h1_0000_0000);
            lvol_start_reg <= '0;
            rvol_start_reg <= '0;
            lstep_reg      <= '0;
            rstep_reg      <= '0;
            pos_int_reg    <= '0;
            pos_frac_reg   <= '0;
            lvol_reg       <= '0;
            rvol_reg       <= '0;
            got_l_reg      <= 1'b0;
            got_r_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIX_MODE:   mode_reg       <= cfg_data[MODE_W-1:0];
                    CFG_POS_INC:    inc_reg        <= cfg_data[POS_W-1:0];
                    CFG_LVOL_START: lvol_start_reg <= cfg_data[VOL_W-1:0];
                    CFG_RVOL_START: rvol_start_reg <= cfg_data[VOL_W-1:0];
                    CFG_LVOL_STEP:  lstep_reg      <= cfg_data[VOL_W-1:0];
                    CFG_RVOL_STEP:  rstep_reg      <= cfg_data[VOL_W-1:0];
                    default:        ;
                endcase
            end

            if (state_reg == ST_IDLE && accept)
            begin
                if (func == FUNC_BEGIN)
                begin
                    pos_frac_reg <= start_position[FRAC_W-1:0];
                    if (reload_volume)
                    begin
                        lvol_reg <= lvol_start_reg;
                        rvol_reg <= rvol_start_reg;
                    end
                end
                got_l_reg <= 1'b0;
                got_r_reg <= 1'b0;
            end

            if (state_reg == ST_BEGIN_WRAP && !wrsp.busy)
            begin
                pos_int_reg <= wrsp.result;
            end

            if (state_reg == ST_MIX_RD0)
            begin
                lvol_reg <= lvol_reg + lstep_reg;
                if (kind == KIND_STEREO)
                begin
                    rvol_reg <= rvol_reg + rstep_reg;
                end
            end

            if (srsp.done)
            begin
                if (!got_l_reg)
                begin
                    got_l_reg <= 1'b1;
                end
                else
                begin
                    got_r_reg <= 1'b1;
                end
            end

            if (state_reg == ST_MIX_WAIT && got_r_reg && !wrsp.busy)
            begin
                pos_int_reg  <= wrsp.result;
                pos_frac_reg <= new_frac_reg;
            end

            if (state_reg == ST_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload and datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            smp_in_reg  <= sample_value;
            accl_in_reg <= accum_left_in;
            accr_in_reg <= accum_right_in;
            res_l_reg   <= '0;
            res_r_reg   <= '0;
            res_mix_reg <= 1'b0;
        end

        if (state_reg == ST_MIX_RD0)
        begin
            new_frac_reg <= frac_sum[FRAC_W-1:0];
        end

        if (state_reg == ST_MIX_RD1)
        begin
            s0_reg  <= rd_s;
            smp_reg <= ram_rdata;
        end

        if (state_reg == ST_MIX_BLEND)
        begin
            blend_reg <= blend_full;
        end

        if (state_reg == ST_MIX_INTERP)
        begin
            smp_reg <= bsum[SAMPLE_W-1:0];
        end

        if (srsp.done)
        begin
            if (!got_l_reg)
            begin
                sl_reg <= srsp.result;
            end
            else
            begin
                sr_reg <= srsp.result;
            end
        end

        if (state_reg == ST_MIX_WAIT && got_r_reg && !wrsp.busy)
        begin
            res_mix_reg <= 1'b1;
            res_l_reg   <= accl_in_reg + sl_reg;
            case (kind)
                KIND_STEREO:   res_r_reg <= accr_in_reg + sr_reg;
                KIND_SURROUND: res_r_reg <= accr_in_reg - sl_reg;
                default:       res_r_reg <= accr_in_reg;
            endcase
        end

        if (state_reg == ST_RESULT && out_free)
        begin
            accl_out_reg  <= res_l_reg;
            accr_out_reg  <= res_r_reg;
            mixed_out_reg <= res_mix_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign accum_left_out  = accl_out_reg;
    assign accum_right_out = accr_out_reg;
    assign mixed           = mixed_out_reg;

endmodule

// ===== test/tb_ramped_volume_sample_mixer.sv =====
// Self-checking testbench for the ramped volume sample mixer: directed and random transactions.
module tb_ramped_volume_sample_mixer;
    import rvsm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [MODE_W-1:0] MODE_MONO            = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MONO_INTERP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STEREO          = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STEREO_INTERP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SURROUND        = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SURROUND_INTERP = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MONO      = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_INTERP    = 3'd7;
    localparam logic [MODE_W-1:0] ALL_MODES [8] = '{MODE_MONO, MODE_MONO_INTERP, MODE_STEREO,
        MODE_STEREO_INTERP, MODE_SURROUND, MODE_SURROUND_INTERP, MODE_SPARE_MONO,
        MODE_SPARE_INTERP};

    localparam logic [POS_W-1:0] INC_MAX     = 44'h7FF_FFFF_FFFF;
    localparam logic [POS_W-1:0] INC_MIN     = 44'h800_0000_0000;
    localparam logic [POS_W-1:0] INC_BACK    = 44'hFFF_0000_0000;
    localparam logic [POS_W-1:0] INC_HALF    = 44'h000_8000_0000;
    localparam logic [POS_W-1:0] INC_UNITY   = 44'h001_0000_0000;
    localparam logic [POS_W-1:0] EDGE_INCS [4] = '{INC_MAX, INC_MIN, INC_BACK, INC_HALF};

    localparam logic [VOL_W-1:0] VOL_MAX = 32'h7FFF_FFFF;
    localparam logic [VOL_W-1:0] VOL_MIN = 32'h8000_0000;
    localparam logic [VOL_W-1:0] STEP_UP = 32'h0000_0001;
    localparam logic [VOL_W-1:0] STEP_DN = 32'hFFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MAX = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 32'h8000_0000;

    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 185;
    localparam int MAX_PRINTED    = 200;

    typedef struct {
        logic [FUNC_W-1:0]          func;
        logic [SADDR_W-1:0]         addr;
        logic signed [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]           start;
        logic                       reload;
        logic signed [ACC_W-1:0]    acc_l;
        logic signed [ACC_W-1:0]    acc_r;
    } voice_cmd_t;

    typedef struct {
        logic signed [ACC_W-1:0] acc_l;
        logic signed [ACC_W-1:0] acc_r;
        logic                    mixed;
    } frame_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [FUNC_W-1:0]            func = '0;
    logic [SADDR_W-1:0]           sample_address = '0;
    logic signed [SAMPLE_W-1:0]   sample_value = '0;
    logic [POS_W-1:0]             start_position = '0;
    logic                         reload_volume = 1'b0;
    logic signed [ACC_W-1:0]      accum_left_in = '0;
    logic signed [ACC_W-1:0]      accum_right_in = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [ACC_W-1:0]      accum_left_out;
    logic signed [ACC_W-1:0]      accum_right_out;
    logic                         mixed;
    logic                         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    // voice model state
    logic signed [SAMPLE_W-1:0]   store [STORE_DEPTH];
    bit                           loaded [STORE_DEPTH];
    logic [POS_W-1:0]             play_pos = '0;
    logic [VOL_W-1:0]             lvol = '0;
    logic [VOL_W-1:0]             rvol = '0;
    logic [MODE_W-1:0]            mode_reg = MODE_MONO;
    logic [POS_W-1:0]             inc_reg = INC_UNITY;
    logic [VOL_W-1:0]             lvol_start = '0;
    logic [VOL_W-1:0]             rvol_start = '0;
    logic [VOL_W-1:0]             lvol_step = '0;
    logic [VOL_W-1:0]             rvol_step = '0;

    frame_t                       pending_frames [$];
    int                           items_sent = 0;
    int                           error_count = 0;
    int                           quiet_cycles = 0;
    int                           stall_left = 0;
    bit                           pacing = 1'b1;

    ramped_volume_sample_mixer i_dut (.*);

    always #6 clk = ~clk;

    function automatic logic [VOL_W-1:0] scaled(logic [VOL_W-1:0] vol,
                                                logic signed [SAMPLE_W-1:0] s);
        int prod;
        prod = int'(vol) * int'(s);
        return prod / VOLUME_DIVISOR;
    endfunction

    function automatic frame_t advance_voice(voice_cmd_t c);
        frame_t                     f;
        logic [ADDR_W-1:0]          ip;
        logic signed [SAMPLE_W-1:0] s0;
        logic signed [SAMPLE_W-1:0] s1;
        logic [VOL_W-1:0]           lscaled;
        longint                     blend;
        f = '{'0, '0, 1'b0};
        case (c.func)
            FUNC_LOAD: begin
                store[c.addr] = c.value;
                loaded[c.addr] = 1'b1;
            end
            FUNC_BEGIN: begin
                play_pos = c.start;
                if (c.reload)
                begin
                    lvol = lvol_start;
                    rvol = rvol_start;
                end
            end
            FUNC_MIX: begin
                ip = play_pos[POS_W-1:FRAC_W];
                s0 = store[ip];
                if (mode_reg[0])
                begin
                    s1 = store[ADDR_W'(ip + 1)];
                    blend = longint'(s1) - longint'(s0);
                    blend = blend * longint'(play_pos[FRAC_W-1 -: INTERP_SHIFT]);
                    blend = longint'(s0) + (blend >>> INTERP_SHIFT);
                    s0 = blend[SAMPLE_W-1:0];
                end
                lvol = lvol + lvol_step;
                lscaled = scaled(lvol, s0);
                f.acc_l = c.acc_l + lscaled;
                f.acc_r = c.acc_r;
                if (mode_reg[2:1] == KIND_STEREO)
                begin
                    rvol = rvol + rvol_step;
                    f.acc_r = c.acc_r + scaled(rvol, s0);
                end
                else if (mode_reg[2:1] == KIND_SURROUND)
                begin
                    f.acc_r = c.acc_r - lscaled;
                end
                play_pos = play_pos + inc_reg;
                f.mixed = 1'b1;
            end
            default: ;
        endcase
        return f;
    endfunction

    function automatic logic [POS_W-1:0] rand44();
        return POS_W'({$urandom, $urandom});
    endfunction

    function automatic logic [VOL_W-1:0] pick_volume();
        case ($urandom_range(0, 5))
            0: return VOL_MAX;
            1: return VOL_MIN;
            2: return '0;
            3: return $urandom;
            default: return VOL_W'($urandom_range(0, 131072)) - VOL_W'(65536);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_increment();
        logic [POS_W-1:0] inc;
        case ($urandom_range(0, 7))
            0: return INC_MAX;
            1: return INC_MIN;
            2: return '0;
            3: return rand44();
            default: begin
                inc = {POS_INT_W'($urandom_range(0, 2)), FRAC_W'($urandom)};
                return $urandom_range(0, 1) ? -inc : inc;
            end
        endcase
    endfunction

    function automatic voice_cmd_t random_cmd(logic [FUNC_W-1:0] f);
        voice_cmd_t c;
        c.func = f;
        c.addr = SADDR_W'($urandom);
        c.value = SAMPLE_W'($urandom);
        c.start = rand44();
        c.reload = 1'($urandom);
        c.acc_l = $urandom;
        c.acc_r = $urandom;
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [ACC_W-1:0] got, logic [ACC_W-1:0] want);
        if (error_count < MAX_PRINTED)
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_item(voice_cmd_t c);
        int gap;
        gap = pacing ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= c.func;
        sample_address <= c.addr;
        sample_value   <= c.value;
        start_position <= c.start;
        reload_volume  <= c.reload;
        accum_left_in  <= c.acc_l;
        accum_right_in <= c.acc_r;
        do
            @(posedge clk);
        while (in_stall);
        pending_frames.push_back(advance_voice(c));
        items_sent++;
    endtask

    task automatic send_load(logic [ADDR_W-1:0] addr, logic [SAMPLE_W-1:0] value);
        voice_cmd_t c;
        c = random_cmd(FUNC_LOAD);
        c.addr = addr;
        c.value = value;
        send_item(c);
    endtask

    task automatic send_begin(logic [POS_W-1:0] start, logic reload);
        voice_cmd_t c;
        c = random_cmd(FUNC_BEGIN);
        c.start = start;
        c.reload = reload;
        send_item(c);
    endtask

    // never read a store entry that has not been written: fill it first
    task automatic send_mix(logic [ACC_W-1:0] acc_l, logic [ACC_W-1:0] acc_r);
        voice_cmd_t        c;
        logic [ADDR_W-1:0] ip;
        ip = play_pos[POS_W-1:FRAC_W];
        if (!loaded[ip])
            send_load(ip, SAMPLE_W'($urandom));
        if (mode_reg[0] && !loaded[ADDR_W'(ip + 1)])
            send_load(ADDR_W'(ip + 1), SAMPLE_W'($urandom));
        c = random_cmd(FUNC_MIX);
        c.acc_l = acc_l;
        c.acc_r = acc_r;
        send_item(c);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_MIX_MODE:   mode_reg = data[MODE_W-1:0];
            CFG_POS_INC:    inc_reg = data[POS_W-1:0];
            CFG_LVOL_START: lvol_start = data[VOL_W-1:0];
            CFG_RVOL_START: rvol_start = data[VOL_W-1:0];
            CFG_LVOL_STEP:  lvol_step = data[VOL_W-1:0];
            CFG_RVOL_STEP:  rvol_step = data[VOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_voice(logic [MODE_W-1:0] mode, logic [POS_W-1:0] inc,
                                 logic [VOL_W-1:0] ls, logic [VOL_W-1:0] rs,
                                 logic [VOL_W-1:0] lst, logic [VOL_W-1:0] rst);
        write_reg(CFG_MIX_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_POS_INC, CFG_DATA_W'(inc));
        write_reg(CFG_LVOL_START, CFG_DATA_W'(ls));
        write_reg(CFG_RVOL_START, CFG_DATA_W'(rs));
        write_reg(CFG_LVOL_STEP, CFG_DATA_W'(lst));
        write_reg(CFG_RVOL_STEP, CFG_DATA_W'(rst));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // loads, begins and the unused code return zero acks; first frame runs on reset settings
    task automatic test_acknowledgements();
        voice_cmd_t c;
        send_load('0, 16'h8000);
        send_load('1, 16'h7FFF);
        send_mix(ACC_MAX, ACC_MIN);
        c = '{FUNC_UNUSED, '1, '1, '1, 1'b1, '1, '1};
        send_item(c);
        send_begin('1, 1'b0);
    endtask

    // each mode once, starting between the last and first entry so the neighbor wraps
    task automatic test_every_mode();
        bit odd;
        for (int m = 0; m < 8; m++)
        begin
            odd = (m % 2) != 0;
            wait_idle();
            program_voice(ALL_MODES[m], EDGE_INCS[m % 4], odd ? VOL_MIN : VOL_MAX,
                          odd ? VOL_MAX : VOL_MIN, odd ? STEP_DN : STEP_UP,
                          odd ? STEP_UP : STEP_DN);
            send_begin({POS_INT_W'('1), FRAC_W'(32'h8000_0000)}, 1'b1);
            send_mix(ACC_MAX, ACC_MIN);
            send_mix(ACC_MIN, ACC_MAX);
        end
    endtask

    task automatic test_random_voice(int phase, int budget);
        int                stop_at;
        int                n;
        int                roll;
        bit                paused;
        logic [ADDR_W-1:0] base;
        wait_idle();
        program_voice(ALL_MODES[phase % 8], pick_increment(), pick_volume(), pick_volume(),
                      pick_volume(), pick_volume());
        pacing = (phase != 2);
        paused = 1'b0;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if (!paused && items_sent >= stop_at - budget / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                base = ADDR_W'($urandom);
                n = $urandom_range(2, 8);
                for (int i = 0; i < n; i++)
                    send_load(ADDR_W'(base + i), SAMPLE_W'($urandom));
                send_begin({base, FRAC_W'($urandom)}, $urandom_range(0, 3) != 0);
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_mix($urandom, $urandom);
            end
            else if (roll < 85)
                send_item(random_cmd(FUNC_UNUSED));
            else if (roll < 93)
                send_load(ADDR_W'($urandom), SAMPLE_W'($urandom));
            else
                send_begin(rand44(), 1'($urandom));
        end
        pacing = 1'b1;
    endtask

    always @(posedge clk)
    begin : result_check
        frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
                report_mismatch("unexpected transaction", accum_left_out, '0);
            else
            begin
                want = pending_frames.pop_front();
                if (accum_left_out !== want.acc_l)
                    report_mismatch("accum_left_out", accum_left_out, want.acc_l);
                if (accum_right_out !== want.acc_r)
                    report_mismatch("accum_right_out", accum_right_out, want.acc_r);
                if (mixed !== want.mixed)
                    report_mismatch("mixed", ACC_W'(mixed), ACC_W'(want.mixed));
            end
            stall_left = pacing ? $urandom_range(0, 10) : 0;
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL ramped_volume_sample_mixer");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_acknowledgements();
        test_every_mode();
        for (int phase = 0; phase < 8; phase++)
            test_random_voice(phase, PHASE_ITEMS);
        wait_idle();
        if (error_count == 0)
            $display("PASS ramped_volume_sample_mixer");
        else
            $display("FAIL ramped_volume_sample_mixer");
        $finish;
    end

endmodule
